// ===== rtl/ntcdc_pkg.sv =====
// Shared types and constants for the NTC divider to Celsius pipeline.
// Used by every cell module and the top level; depends on nothing.
package ntcdc_pkg;

  localparam int TEMP_FRACTION_BITS = 8;
  localparam int LOG_FRAC = 24;

  // restoring divider: numerator width covers beta << (LOG_FRAC + F) plus rounding
  localparam int DIV_W = (TEMP_FRACTION_BITS + 41 > 48) ? TEMP_FRACTION_BITS + 41 : 48;
  localparam int DVS_W = 34;
  localparam int REM_W = DVS_W + 1;
  localparam int NORM_STEPS = 6;
  localparam int LOG_STEPS = LOG_FRAC;
  localparam int ZW = 64;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  // A = (beta * 100 * 2^24 + 14907) / 29815, split as
  // beta * A_WHOLE + (beta * A_FRAC + A_ROUND) / 29815
  localparam logic [15:0] A_WHOLE = 16'd56271;
  localparam logic [10:0] A_FRAC = 11'd1735;
  localparam logic [26:0] A_ROUND = 27'd14907;
  // exact floor(x / 29815) for x below 2^27: (x * A_RECIP) >> A_SHIFT
  localparam logic [27:0] A_RECIP = 28'd147511203;
  localparam int A_SHIFT = 42;
  localparam int OFFS = ((27315 << TEMP_FRACTION_BITS) + 50) / 100;
  localparam int CEL_MAX = 65535;
  localparam int CEL_MIN = -65536;
  localparam logic [5:0] K_START = 6'd39;

  localparam logic [7:0] REG_EXCITATION = 8'd0;
  localparam logic [7:0] REG_FIXED_R = 8'd1;
  localparam logic [7:0] REG_NOMINAL_R = 8'd2;
  localparam logic [7:0] REG_BETA = 8'd3;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BAD_SETUP = 3'd1,
    ST_BAD_VOLTAGE = 3'd2,
    ST_BAD_BETA = 3'd3,
    ST_CONV_ERROR = 3'd4
  } status_t;

  typedef struct packed {
    status_t status;
    logic [15:0] beta;
    logic [39:0] num;
    logic [39:0] den;
    logic [31:0] resistance;
    logic res_sat;
    logic [31:0] a;
    logic neg;
    logic [29:0] mag;
    logic [29:0] lln;
    logic signed [33:0] d;
  } rec_t;

  typedef struct packed {
    logic [DIV_W-1:0] n;
    logic [REM_W-1:0] r;
    logic [DVS_W-1:0] d;
  } div_lane_t;

  typedef struct packed {
    logic [ZW-1:0] z;
    logic [5:0] k;
  } norm_lane_t;

  typedef struct packed {
    logic [30:0] m;
    logic [5:0] k;
    logic [LOG_FRAC-1:0] frac;
  } log_lane_t;

endpackage

// ===== rtl/ntc_divider_to_celsius_top.sv =====
// NTC divider to Celsius: resistance division, log2 by squaring, beta equation.
// Stages in order: front, resistance divider, normalize, log, combine, temperature
// divider, output. Throughput one item per cycle; the whole pipeline holds
// while a result waits at the output. Synchronous reset clears all valid bits
// and loads the register defaults (3300 mV, 10000 ohm, 10000 ohm, 3950 K).
module ntc_divider_to_celsius_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [15:0] node_millivolts,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] status,
  output logic [31:0] resistance_ohms,
  output logic signed [16:0] celsius_q8,
  output logic saturated,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DW = ntcdc_pkg::DIV_W;

  logic [15:0] excitation;
  logic [23:0] fixed_r;
  logic [23:0] nominal_r;
  logic [15:0] beta_k;
  logic adv;

  assign cfg_ready = 1'b1;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      excitation <= 16'd3300;
      fixed_r <= 24'd10000;
      nominal_r <= 24'd10000;
      beta_k <= 16'd3950;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ntcdc_pkg::REG_EXCITATION: excitation <= cfg_data[15:0];
        ntcdc_pkg::REG_FIXED_R: fixed_r <= cfg_data[23:0];
        ntcdc_pkg::REG_NOMINAL_R: nominal_r <= cfg_data[23:0];
        ntcdc_pkg::REG_BETA: beta_k <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- front stage ----------------
  logic f_valid;
  ntcdc_pkg::rec_t f_rec, f_rec_next;
  ntcdc_pkg::div_lane_t [1:0] f_lanes, f_lanes_next;

  always_comb begin
    logic [15:0] dv;
    logic [26:0] afrac;
    dv = excitation - node_millivolts;
    afrac = 27'(beta_k) * 27'(ntcdc_pkg::A_FRAC) + ntcdc_pkg::A_ROUND;
    f_rec_next = '0;
    if (excitation == '0 || fixed_r == '0) begin
      f_rec_next.status = ntcdc_pkg::ST_BAD_SETUP;
    end else if (node_millivolts == '0 || node_millivolts >= excitation) begin
      f_rec_next.status = ntcdc_pkg::ST_BAD_VOLTAGE;
    end else if (nominal_r == '0 || beta_k == '0) begin
      f_rec_next.status = ntcdc_pkg::ST_BAD_BETA;
    end else begin
      f_rec_next.status = ntcdc_pkg::ST_OK;
    end
    f_rec_next.beta = beta_k;
    f_rec_next.num = 40'(fixed_r) * 40'(node_millivolts);
    f_rec_next.den = 40'(dv) * 40'(nominal_r);
    // carry the fractional part of A until it is scaled after the divider
    f_rec_next.a = 32'(afrac);
    f_lanes_next[0].n = DW'(f_rec_next.num);
    f_lanes_next[0].r = '0;
    f_lanes_next[0].d = ntcdc_pkg::DVS_W'(dv);
    f_lanes_next[1] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_rec <= f_rec_next;
      f_lanes <= f_lanes_next;
    end
  end

  // ---------------- resistance division ----------------
  logic d1_valid [0:DW];
  ntcdc_pkg::rec_t d1_rec [0:DW];
  ntcdc_pkg::div_lane_t [1:0] d1_lanes [0:DW];

  assign d1_valid[0] = f_valid;
  assign d1_rec[0] = f_rec;
  assign d1_lanes[0] = f_lanes;

  for (genvar i = 0; i < DW; i++) begin : g_div1
    ntcdc_div_cell u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .valid_in(d1_valid[i]), .rec_in(d1_rec[i]), .lanes_in(d1_lanes[i]),
      .valid(d1_valid[i+1]), .rec(d1_rec[i+1]), .lanes(d1_lanes[i+1])
    );
  end

  // saturate resistance, form A, set up normalization
  ntcdc_pkg::rec_t p_rec;
  ntcdc_pkg::norm_lane_t [1:0] p_lanes;

  always_comb begin
    logic [DW-1:0] q;
    logic [54:0] qa;
    p_rec = d1_rec[DW];
    q = d1_lanes[DW][0].n;
    if (q[DW-1:32] != '0) begin
      p_rec.resistance = 32'hFFFF_FFFF;
      p_rec.res_sat = 1'b1;
    end else begin
      p_rec.resistance = q[31:0];
      p_rec.res_sat = 1'b0;
    end
    if (p_rec.status == ntcdc_pkg::ST_BAD_SETUP
        || p_rec.status == ntcdc_pkg::ST_BAD_VOLTAGE) begin
      p_rec.resistance = '0;
      p_rec.res_sat = 1'b0;
    end
    qa = 55'(d1_rec[DW].a[26:0]) * 55'(ntcdc_pkg::A_RECIP);
    p_rec.a = 32'(d1_rec[DW].beta) * 32'(ntcdc_pkg::A_WHOLE)
            + 32'(qa >> ntcdc_pkg::A_SHIFT);
    p_lanes[0].z = {p_rec.num, 24'd0};
    p_lanes[0].k = ntcdc_pkg::K_START;
    p_lanes[1].z = {p_rec.den, 24'd0};
    p_lanes[1].k = ntcdc_pkg::K_START;
  end

  // ---------------- normalization ----------------
  logic nm_valid [0:ntcdc_pkg::NORM_STEPS];
  ntcdc_pkg::rec_t nm_rec [0:ntcdc_pkg::NORM_STEPS];
  ntcdc_pkg::norm_lane_t [1:0] nm_lanes [0:ntcdc_pkg::NORM_STEPS];

  assign nm_valid[0] = d1_valid[DW];
  assign nm_rec[0] = p_rec;
  assign nm_lanes[0] = p_lanes;

  for (genvar i = 0; i < ntcdc_pkg::NORM_STEPS; i++) begin : g_norm
    ntcdc_norm_cell u_cell (
      .clk(clk), .rst(rst), .en(adv), .shamt(6'(32 >> i)),
      .valid_in(nm_valid[i]), .rec_in(nm_rec[i]), .lanes_in(nm_lanes[i]),
      .valid(nm_valid[i+1]), .rec(nm_rec[i+1]), .lanes(nm_lanes[i+1])
    );
  end

  // ---------------- log2 by squaring ----------------
  localparam int LS = ntcdc_pkg::LOG_STEPS;
  logic lg_valid [0:LS];
  ntcdc_pkg::rec_t lg_rec [0:LS];
  ntcdc_pkg::log_lane_t [1:0] lg_lanes [0:LS];

  assign lg_valid[0] = nm_valid[ntcdc_pkg::NORM_STEPS];
  assign lg_rec[0] = nm_rec[ntcdc_pkg::NORM_STEPS];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lg_lanes[0][i].m = nm_lanes[ntcdc_pkg::NORM_STEPS][i].z[63:33];
      lg_lanes[0][i].k = nm_lanes[ntcdc_pkg::NORM_STEPS][i].k;
      lg_lanes[0][i].frac = '0;
    end
  end

  for (genvar i = 0; i < LS; i++) begin : g_log
    ntcdc_log_cell u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .valid_in(lg_valid[i]), .rec_in(lg_rec[i]), .lanes_in(lg_lanes[i]),
      .valid(lg_valid[i+1]), .rec(lg_rec[i+1]), .lanes(lg_lanes[i+1])
    );
  end

  // ---------------- combine: L, L*ln2, D ----------------
  logic l_valid, m_valid, dd_valid;
  ntcdc_pkg::rec_t l_rec, l_rec_next, m_rec, m_rec_next, dd_rec, dd_rec_next;

  always_comb begin
    logic signed [30:0] lval;
    l_rec_next = lg_rec[LS];
    lval = $signed({1'b0, lg_lanes[LS][0].k, lg_lanes[LS][0].frac})
         - $signed({1'b0, lg_lanes[LS][1].k, lg_lanes[LS][1].frac});
    l_rec_next.neg = lval[30];
    l_rec_next.mag = lval[30] ? 30'(-lval) : lval[29:0];
  end

  always_comb begin
    logic [62:0] prod;
    m_rec_next = l_rec;
    prod = 63'(l_rec.mag) * 63'(ntcdc_pkg::LN2_Q32) + 63'(64'h8000_0000);
    m_rec_next.lln = prod[61:32];
  end

  always_comb begin
    logic signed [33:0] lsig;
    dd_rec_next = m_rec;
    lsig = $signed({4'd0, m_rec.lln});
    dd_rec_next.d = $signed({2'b0, m_rec.a}) + (m_rec.neg ? -lsig : lsig);
    if (dd_rec_next.status == ntcdc_pkg::ST_OK
        && (dd_rec_next.d[33] || dd_rec_next.d == '0)) begin
      dd_rec_next.status = ntcdc_pkg::ST_CONV_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
      m_valid <= 1'b0;
      dd_valid <= 1'b0;
    end else if (adv) begin
      l_valid <= lg_valid[LS];
      m_valid <= l_valid;
      dd_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_rec <= l_rec_next;
      m_rec <= m_rec_next;
      dd_rec <= dd_rec_next;
    end
  end

  // ---------------- temperature division ----------------
  logic d2_valid [0:DW];
  ntcdc_pkg::rec_t d2_rec [0:DW];
  ntcdc_pkg::div_lane_t [1:0] d2_lanes [0:DW];

  assign d2_valid[0] = dd_valid;
  assign d2_rec[0] = dd_rec;

  always_comb begin
    d2_lanes[0][0].n =
        (DW'(dd_rec.beta) << (ntcdc_pkg::LOG_FRAC + ntcdc_pkg::TEMP_FRACTION_BITS))
        + DW'(dd_rec.d[33:1]);
    d2_lanes[0][0].r = '0;
    d2_lanes[0][0].d = dd_rec.d;
    d2_lanes[0][1] = '0;
  end

  for (genvar i = 0; i < DW; i++) begin : g_div2
    ntcdc_div_cell u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .valid_in(d2_valid[i]), .rec_in(d2_rec[i]), .lanes_in(d2_lanes[i]),
      .valid(d2_valid[i+1]), .rec(d2_rec[i+1]), .lanes(d2_lanes[i+1])
    );
  end

  // ---------------- output register ----------------
  ntcdc_pkg::rec_t o_rec;
  logic signed [16:0] cel_next;
  logic sat_next;

  always_comb begin
    logic signed [DW+1:0] c;
    o_rec = d2_rec[DW];
    c = $signed({2'b0, d2_lanes[DW][0].n}) - (DW+2)'(ntcdc_pkg::OFFS);
    cel_next = '0;
    sat_next = o_rec.res_sat;
    if (o_rec.status == ntcdc_pkg::ST_OK) begin
      if (c > (DW+2)'(ntcdc_pkg::CEL_MAX)) begin
        cel_next = 17'(ntcdc_pkg::CEL_MAX);
        sat_next = 1'b1;
      end else if (c < (DW+2)'(ntcdc_pkg::CEL_MIN)) begin
        cel_next = 17'(ntcdc_pkg::CEL_MIN);
        sat_next = 1'b1;
      end else begin
        cel_next = c[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d2_valid[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status <= o_rec.status;
      resistance_ohms <= o_rec.resistance;
      celsius_q8 <= cel_next;
      saturated <= sat_next;
    end
  end

endmodule

// ===== rtl/ntcdc_div_cell.sv =====
// One restoring division step for two lanes, plus the item record.
// Depends on ntcdc_pkg.
module ntcdc_div_cell (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic valid_in,
  input  ntcdc_pkg::rec_t rec_in,
  input  ntcdc_pkg::div_lane_t [1:0] lanes_in,
  output logic valid,
  output ntcdc_pkg::rec_t rec,
  output ntcdc_pkg::div_lane_t [1:0] lanes
);

  ntcdc_pkg::div_lane_t [1:0] lanes_next;

  always_comb begin
    logic [ntcdc_pkg::REM_W-1:0] rs;
    logic ge;
    for (int i = 0; i < 2; i++) begin
      rs = {lanes_in[i].r[ntcdc_pkg::REM_W-2:0], lanes_in[i].n[ntcdc_pkg::DIV_W-1]};
      ge = rs >= {1'b0, lanes_in[i].d};
      lanes_next[i].d = lanes_in[i].d;
      lanes_next[i].r = ge ? rs - {1'b0, lanes_in[i].d} : rs;
      lanes_next[i].n = {lanes_in[i].n[ntcdc_pkg::DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rec <= rec_in;
      lanes <= lanes_next;
    end
  end

endmodule

// ===== rtl/ntcdc_norm_cell.sv =====
// One normalization step for two lanes: shift left by a fixed amount when the
// top bits are clear and lower the exponent. Depends on ntcdc_pkg.
module ntcdc_norm_cell (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [5:0] shamt,
  input  logic valid_in,
  input  ntcdc_pkg::rec_t rec_in,
  input  ntcdc_pkg::norm_lane_t [1:0] lanes_in,
  output logic valid,
  output ntcdc_pkg::rec_t rec,
  output ntcdc_pkg::norm_lane_t [1:0] lanes
);

  ntcdc_pkg::norm_lane_t [1:0] lanes_next;
  logic [6:0] rsh;

  assign rsh = 7'd64 - {1'b0, shamt};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if ((lanes_in[i].z >> rsh) == '0) begin
        lanes_next[i].z = lanes_in[i].z << shamt;
        lanes_next[i].k = lanes_in[i].k - shamt;
      end else begin
        lanes_next[i] = lanes_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rec <= rec_in;
      lanes <= lanes_next;
    end
  end

endmodule

// ===== rtl/ntcdc_log_cell.sv =====
// One log2 fraction bit by squaring for two lanes, plus the item record.
// Depends on ntcdc_pkg.
module ntcdc_log_cell (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic valid_in,
  input  ntcdc_pkg::rec_t rec_in,
  input  ntcdc_pkg::log_lane_t [1:0] lanes_in,
  output logic valid,
  output ntcdc_pkg::rec_t rec,
  output ntcdc_pkg::log_lane_t [1:0] lanes
);

  ntcdc_pkg::log_lane_t [1:0] lanes_next;

  always_comb begin
    logic [61:0] sq;
    logic [31:0] mm;
    for (int i = 0; i < 2; i++) begin
      sq = 62'(lanes_in[i].m) * 62'(lanes_in[i].m);
      mm = sq[61:30];
      lanes_next[i].k = lanes_in[i].k;
      // renormalize into [1,2) and take the bit
      lanes_next[i].m = mm[31] ? mm[31:1] : mm[30:0];
      lanes_next[i].frac = {lanes_in[i].frac[ntcdc_pkg::LOG_FRAC-2:0], mm[31]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rec <= rec_in;
      lanes <= lanes_next;
    end
  end

endmodule

// ===== test/ntc_divider_to_celsius_top_tb.sv =====
// Testbench for the NTC divider to Celsius pipeline: drives node voltages with random
// gaps and stalls, predicts each result in fixed point and checks it in order.
// Depends on ntcdc_pkg and ntc_divider_to_celsius_top.
module ntc_divider_to_celsius_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH = 140;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    ntcdc_pkg::status_t status;
    logic [31:0] resistance;
    logic signed [16:0] celsius;
    logic sat;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] node_millivolts = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [31:0] resistance_ohms;
  logic signed [16:0] celsius_q8;
  logic saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // configuration copy kept by the predictor
  logic [15:0] excite_mv;
  logic [23:0] fixed_ohms;
  logic [23:0] r25_ohms;
  logic [15:0] beta_k;

  reading_t pending_readings[$];
  int mismatches = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit steady = 0;

  ntc_divider_to_celsius_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint log2_q24(logic [63:0] x);
    int k;
    logic [63:0] m;
    longint acc;
    k = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    m = (k <= 30) ? x << (30 - k) : x >> (k - 30);
    acc = longint'(k) <<< 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        acc += longint'(1) <<< i;
      end
    end
    return acc;
  endfunction

  function automatic reading_t predict_reading(logic [15:0] node);
    reading_t rd;
    logic [63:0] num, dv, r, den, mag, tnum;
    longint lval, lln, d, t, c;
    rd = '{ntcdc_pkg::ST_OK, 32'd0, 17'sd0, 1'b0};
    if (excite_mv == 0 || fixed_ohms == 0) begin
      rd.status = ntcdc_pkg::ST_BAD_SETUP;
      return rd;
    end
    if (node == 0 || node >= excite_mv) begin
      rd.status = ntcdc_pkg::ST_BAD_VOLTAGE;
      return rd;
    end
    num = 64'(fixed_ohms) * 64'(node);
    dv = 64'(excite_mv) - 64'(node);
    r = num / dv;
    if (r > 64'hFFFF_FFFF) begin
      r = 64'hFFFF_FFFF;
      rd.sat = 1'b1;
    end
    rd.resistance = r[31:0];
    if (r25_ohms == 0 || beta_k == 0) begin
      rd.status = ntcdc_pkg::ST_BAD_BETA;
      return rd;
    end
    den = dv * 64'(r25_ohms);
    lval = log2_q24(num) - log2_q24(den);
    mag = (lval < 0) ? 64'(-lval) : 64'(lval);
    lln = longint'((mag * 64'd2977044472 + 64'h8000_0000) >> 32);
    if (lval < 0) lln = -lln;
    d = longint'(((64'(beta_k) * 64'd100 << 24) + 64'd14907) / 64'd29815) + lln;
    if (d <= 0) begin
      rd.status = ntcdc_pkg::ST_CONV_ERROR;
      return rd;
    end
    tnum = 64'(beta_k) << (24 + ntcdc_pkg::TEMP_FRACTION_BITS);
    t = longint'((tnum + 64'(d) / 2) / 64'(d));
    c = t - longint'(((27315 << ntcdc_pkg::TEMP_FRACTION_BITS) + 50) / 100);
    if (c > 65535) begin
      c = 65535;
      rd.sat = 1'b1;
    end
    if (c < -65536) begin
      c = -65536;
      rd.sat = 1'b1;
    end
    rd.celsius = c[16:0];
    return rd;
  endfunction

  // result side: check every accepted item, then draw the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      reading_t got, want;
      got = '{ntcdc_pkg::status_t'(status), resistance_ohms, celsius_q8, saturated};
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p actual %p", want, got);
        end
      end
      stall_left = steady ? 0 : int'($urandom_range(0, 7));
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_node(logic [15:0] node);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    node_millivolts <= node;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(predict_reading(node));
  endtask

  // drop valid, wait for every result, then let the pipeline empty
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ntcdc_pkg::REG_EXCITATION: excite_mv = data[15:0];
      ntcdc_pkg::REG_FIXED_R: fixed_ohms = data[23:0];
      ntcdc_pkg::REG_NOMINAL_R: r25_ohms = data[23:0];
      ntcdc_pkg::REG_BETA: beta_k = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_divider(logic [15:0] e, logic [23:0] rf, logic [23:0] r25,
                             logic [15:0] b);
    drain();
    write_cfg(ntcdc_pkg::REG_EXCITATION, {$urandom} & 32'hFFFF_0000 | 32'(e));
    write_cfg(ntcdc_pkg::REG_FIXED_R, {$urandom} & 32'hFF00_0000 | 32'(rf));
    write_cfg(ntcdc_pkg::REG_NOMINAL_R, 32'(r25));
    write_cfg(ntcdc_pkg::REG_BETA, 32'(b));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults;
    send_node(16'd1);
    send_node(16'd1650);
    send_node(16'd3299);
    send_node(16'd3300);
    send_node(16'd0);
    send_node(16'hFFFF);
    send_node(16'd330);
    send_node(16'd2970);
  endtask

  task automatic test_special_cases;
    set_divider(16'd0, 24'd10000, 24'd10000, 16'd3950);
    send_node(16'd100);
    set_divider(16'd3300, 24'd0, 24'd10000, 16'd3950);
    send_node(16'd100);
    set_divider(16'd3300, 24'd10000, 24'd0, 16'd3950);
    send_node(16'd1000);
    set_divider(16'd3300, 24'd10000, 24'd10000, 16'd0);
    send_node(16'd1000);
    // tiny beta with a huge nominal resistance pushes 1/T below zero
    set_divider(16'd3300, 24'd10, 24'hFFFFFF, 16'd1);
    send_node(16'd1);
    send_node(16'd3000);
    // resistance clipping
    set_divider(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_node(16'hFFFE);
    send_node(16'd1);
    send_node(16'h8000);
    // temperature with extreme beta and divider settings
    set_divider(16'd1000, 24'd10000, 24'd10000, 16'd1);
    send_node(16'd500);
    send_node(16'd501);
    set_divider(16'd1000, 24'd1, 24'hFFFFFF, 16'hFFFF);
    send_node(16'd999);
    drain();
    // an index past the last register changes nothing
    write_cfg(8'd4, 32'd0);
    write_cfg(8'hFF, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_node(16'd500);
  endtask

  task automatic test_random;
    logic [15:0] e, node;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: set_divider(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        1: set_divider(16'd2, 24'd1, 24'd1, 16'd1);
        2: set_divider(16'd3300, 24'd10000, 24'd10000, 16'd3950);
        3: set_divider(16'd5000, 24'd100000, 24'd100000, 16'd4250);
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            set_divider(16'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
          end else begin
            set_divider(16'($urandom_range(1, 65535)), 24'($urandom_range(1, 24'hFFFFFF)),
                        24'($urandom_range(1, 24'hFFFFFF)),
                        16'($urandom_range(1000, 6000)));
          end
        end
      endcase
      e = excite_mv;
      for (int n = 0; n < 95; n++) begin
        if (n % 25 == 0) steady = ($urandom_range(0, 3) == 0);
        if (n == 50) begin
          in_valid <= 1'b0;
          while (pending_readings.size() != 0) @(posedge clk);
        end
        case ($urandom_range(0, 9))
          0: node = 16'($urandom);
          1: node = (e > 1) ? e - 16'd1 - 16'($urandom_range(0, 3)) : 16'd0;
          2: node = 16'($urandom_range(0, 3));
          default: node = (e > 1) ? 16'($urandom_range(1, e - 1)) : 16'($urandom);
        endcase
        send_node(node);
      end
      steady = 0;
    end
  endtask

  initial begin
    excite_mv = 16'd3300;
    fixed_ohms = 24'd10000;
    r25_ohms = 24'd10000;
    beta_k = 16'd3950;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_special_cases();
    test_random();
    drain();
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
